[rtl/core/ccbp_pkg.sv]
// Shared types, register indexes and the codeword function for the CRC codeword bit packer.
// No dependencies; every other file of the block imports this package.
package ccbp_pkg;

  localparam int unsigned MAX_GEN_LENGTH = 9;
  localparam int unsigned GEN_W          = 9;
  localparam int unsigned GLEN_W         = 4;
  localparam int unsigned CW_W           = 16;
  localparam int unsigned ACC_W          = 31;
  localparam int unsigned WORD_W         = 24;

  typedef enum logic [1:0] {
    REG_GEN_BITS  = 2'd0,
    REG_GEN_LEN   = 2'd1,
    REG_WORD_SEL  = 2'd2,
    REG_LEAD_PAD  = 2'd3
  } ccbp_reg_t;

  typedef struct packed {
    logic [GEN_W-1:0]  gen_bits;
    logic [GLEN_W-1:0] gen_len;
    logic              wide;
    logic [2:0]        lead_pad;
  } ccbp_cfg_t;

  // One queue entry: the completed bytes of one item, first byte highest.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [1:0]        nbytes;
  } ccbp_entry_t;

  // Codeword of one dataword: the dataword followed by the long-division remainder.
  // The division runs positionwise and does not assume a leading one.
  function automatic logic [CW_W-1:0] crc_codeword(input logic [7:0]        data,
                                                   input logic              wide,
                                                   input logic [GLEN_W-1:0] glen,
                                                   input logic [GEN_W-1:0]  gen);
    logic [3:0]       checks;
    logic [4:0]       dlen;
    logic [GEN_W:0]   gmask;
    logic [GEN_W-1:0] genm;
    logic [CW_W-1:0]  work;
    logic [CW_W-1:0]  rmask;
    logic [4:0]       pos;
    checks = glen - 4'd1;
    dlen   = wide ? 5'd8 : 5'd4;
    gmask  = ((GEN_W+1)'(1) << glen) - (GEN_W+1)'(1);
    genm   = gen & gmask[GEN_W-1:0];
    work   = CW_W'(data) << checks;
    for (int i = 0; i < 8; i++) begin
      if (5'(i) < dlen) begin
        pos = dlen + 5'(checks) - 5'd1 - 5'(i);
        if (work[pos[3:0]]) begin
          work = work ^ (CW_W'(genm) << (dlen - 5'd1 - 5'(i)));
        end
      end
    end
    rmask = (CW_W'(1) << checks) - CW_W'(1);
    return (CW_W'(data) << checks) | (work & rmask);
  endfunction

endpackage

[rtl/core/crc_codeword_bit_packer_core.sv]
// Top level of the CRC codeword bit packer: configuration registers, front, queue and back.
// Depends on ccbp_pkg, ccbp_front, ccbp_queue and ccbp_back.
//
//   port group   direction   contents
//   in_*         input       data_byte, first_byte; valid/ready
//   out_*        output      out_byte, last; valid/ready
//   cfg_*        input       index, data; valid/ready, always ready
//
// The front takes an item in the cycle it arrives whenever the two-entry queue has room.
// Each item gives one to three bytes; the back sends one byte a cycle while out_ready is
// high, so the output port sets the sustained item rate.
// Reset is synchronous; it clears held bits, queue pointers and output valid.
// A stall at the output fills the queue and then lowers in_ready.
module crc_codeword_bit_packer_core
  import ccbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic              in_first_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_out_byte,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [GEN_W-1:0]  cfg_data
);

  ccbp_cfg_t   cfg_r;
  ccbp_entry_t q_entry;
  ccbp_entry_t q_head;
  logic        q_push;
  logic        q_full;
  logic        q_pop;
  logic        q_nonempty;
  logic [1:0]  q_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gen_bits <= '0;
      cfg_r.gen_len  <= GLEN_W'(1);
      cfg_r.wide     <= 1'b0;
      cfg_r.lead_pad <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GEN_BITS: cfg_r.gen_bits <= cfg_data;
        REG_GEN_LEN:  cfg_r.gen_len  <= cfg_data[GLEN_W-1:0];
        REG_WORD_SEL: cfg_r.wide     <= cfg_data[0];
        REG_LEAD_PAD: cfg_r.lead_pad <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  ccbp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_first_byte (in_first_byte),
    .q_push        (q_push),
    .q_full        (q_full),
    .q_entry       (q_entry)
  );

  ccbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .nonempty   (q_nonempty),
    .head       (q_head),
    .level      (q_level)
  );

  ccbp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_nonempty   (q_nonempty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_out_byte (out_out_byte),
    .out_last     (out_last)
  );

  // The queue never holds more than its two entries.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_level != 2'd3) else $error("queue level out of range");

  // Every queued item carries at least one byte.
  a_entry_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    q_nonempty |-> q_head.nbytes != 2'd0) else $error("empty item in queue");

  // The back only retires an entry that is present.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_nonempty) else $error("pop from empty queue");

  // A full queue holds off the input side.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (q_level == 2'd2) |-> !in_ready) else $error("input taken while queue full");

endmodule

[rtl/core/ccbp_front.sv]
// Front part: accepts input items, builds their codewords, packs them behind the held bits
// and pushes the completed bytes into the queue. Depends on ccbp_pkg.
module ccbp_front
  import ccbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  ccbp_cfg_t   cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  output logic        q_push,
  input  logic        q_full,
  output ccbp_entry_t q_entry
);

  logic [6:0]        pend_bits_r, pend_bits_nxt;
  logic [2:0]        pend_cnt_r, pend_cnt_nxt;
  logic [GLEN_W-1:0] glen;
  logic [4:0]        clen;
  logic [4:0]        codelen;
  logic [CW_W-1:0]   cw_hi, cw_lo;
  logic [WORD_W-1:0] codes;
  logic [6:0]        pend_in;
  logic [2:0]        cnt_in;
  logic [ACC_W-1:0]  acc;
  logic [4:0]        ntot;
  logic [2:0]        rem;
  logic              accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (cfg.gen_len == '0) begin
      glen = GLEN_W'(1);
    end else if (cfg.gen_len > GLEN_W'(MAX_GEN_LENGTH)) begin
      glen = GLEN_W'(MAX_GEN_LENGTH);
    end else begin
      glen = cfg.gen_len;
    end
    clen = (cfg.wide ? 5'd8 : 5'd4) + 5'(glen) - 5'd1;

    // In narrow mode the high nibble is the first dataword.
    cw_hi = crc_codeword(cfg.wide ? in_data_byte : {4'b0, in_data_byte[7:4]},
                         cfg.wide, glen, cfg.gen_bits);
    cw_lo = crc_codeword({4'b0, in_data_byte[3:0]}, cfg.wide, glen, cfg.gen_bits);

    if (cfg.wide) begin
      codes   = WORD_W'(cw_hi);
      codelen = clen;
    end else begin
      codes   = (WORD_W'(cw_hi) << clen) | WORD_W'(cw_lo);
      codelen = clen << 1;
    end

    pend_in = in_first_byte ? 7'd0 : pend_bits_r;
    cnt_in  = in_first_byte ? cfg.lead_pad : pend_cnt_r;

    acc  = (ACC_W'(pend_in) << codelen) | ACC_W'(codes);
    ntot = 5'(cnt_in) + codelen;
    rem  = ntot[2:0];

    q_entry.word   = WORD_W'(acc >> rem);
    q_entry.nbytes = ntot[4:3];

    pend_bits_nxt = acc[6:0] & ((7'd1 << rem) - 7'd1);
    pend_cnt_nxt  = rem;
  end

  assign q_push = accept && (ntot[4:3] != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (accept) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

[rtl/core/ccbp_queue.sv]
// Two-entry queue between the front and back parts of the packer.
// Depends on ccbp_pkg for the entry type.
module ccbp_queue
  import ccbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  ccbp_entry_t push_entry,
  output logic        full,
  input  logic        pop,
  output logic        nonempty,
  output ccbp_entry_t head,
  output logic [1:0]  level
);

  ccbp_entry_t mem [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  level_r, level_nxt;

  assign full     = (level_r == 2'd2);
  assign nonempty = (level_r != 2'd0);
  assign head     = mem[rd_ptr_r];
  assign level    = level_r;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    level_nxt  = level_r + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

[rtl/core/ccbp_back.sv]
// Back part: walks the bytes of the queue head one a cycle, while the output is not stalled, into the output register.
// Depends on ccbp_pkg for the entry type.
module ccbp_back
  import ccbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nonempty,
  input  ccbp_entry_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_byte,
  output logic        out_last
);

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic [1:0] idx_r, idx_nxt;
  logic [1:0] sel;
  logic [7:0] byte_nxt;
  logic       last_nxt;
  logic       load;

  assign load = q_nonempty && (!out_valid_r || out_ready);

  always_comb begin
    // The first byte of an item sits highest in its word.
    sel      = q_head.nbytes - 2'd1 - idx_r;
    last_nxt = (idx_r == q_head.nbytes - 2'd1);
    case (sel)
      2'd0:    byte_nxt = q_head.word[7:0];
      2'd1:    byte_nxt = q_head.word[15:8];
      2'd2:    byte_nxt = q_head.word[23:16];
      default: byte_nxt = '0;
    endcase
    q_pop         = load && last_nxt;
    idx_nxt       = load ? (last_nxt ? 2'd0 : idx_r + 2'd1) : idx_r;
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_out_byte = byte_r;
  assign out_last     = last_r;

endmodule

[sim/tb.sv]
// Self-checking testbench for crc_codeword_bit_packer_core: items go through a queue-fed driver,
// and a monitor predicts the packed codeword bytes and checks each one against the output.
// Depends on ccbp_pkg and the RTL of the block.
module tb
  import ccbp_pkg::*;
();

  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } raw_item_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
  } coded_byte_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       in_data_byte = '0;
  logic             in_first_byte = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_out_byte;
  logic             out_last;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [GEN_W-1:0] cfg_data = '0;

  // Shadow of the configuration registers and of the held partial byte.
  logic [8:0] gen_bits_sh = '0;
  logic [3:0] gen_len_sh = 4'd1;
  logic       wide_sh = 1'b0;
  logic [2:0] lead_pad_sh = '0;
  logic [6:0] held_bits = '0;
  logic [2:0] held_count = '0;

  raw_item_t   pending_items[$];
  coded_byte_t expected_bytes[$];
  raw_item_t   next_item;
  coded_byte_t want;
  int          errors = 0;
  int          items_taken = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          rx_hold_left = 0;
  logic        sender_hold = 1'b0;

  crc_codeword_bit_packer_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_first_byte(in_first_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_out_byte (out_out_byte),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // Dataword followed by the remainder of positionwise long division by the generator.
  function automatic logic [15:0] build_codeword(logic [7:0] word, int dlen, int glen);
    int          chk;
    logic [8:0]  gpoly;
    logic [31:0] rem;
    chk = glen - 1;
    gpoly = gen_bits_sh & 9'((32'd1 << glen) - 1);
    rem = 32'(word) << chk;
    for (int i = 0; i < dlen; i++) begin
      if (rem[dlen + chk - 1 - i]) begin
        rem = rem ^ (32'(gpoly) << (dlen - 1 - i));
      end
    end
    return 16'((32'(word) << chk) | (rem & ((32'd1 << chk) - 1)));
  endfunction

  task automatic encode_item(logic [7:0] data, logic first);
    int          glen;
    int          dlen;
    int          clen;
    int          nbits;
    int          produced;
    logic [31:0] acc;
    logic [7:0]  word;
    coded_byte_t cb;
    if (gen_len_sh == 4'd0) glen = 1;
    else if (gen_len_sh > MAX_GEN_LENGTH) glen = MAX_GEN_LENGTH;
    else glen = gen_len_sh;
    dlen = wide_sh ? 8 : 4;
    clen = dlen + glen - 1;
    if (first) begin
      acc = '0;
      nbits = lead_pad_sh;
    end else begin
      acc = 32'(held_bits);
      nbits = held_count;
    end
    produced = 0;
    for (int p = 0; p < 8 / dlen; p++) begin
      if (dlen == 8) word = data;
      else word = (p == 0) ? {4'h0, data[7:4]} : {4'h0, data[3:0]};
      acc = (acc << clen) | 32'(build_codeword(word, dlen, glen));
      nbits += clen;
      while (nbits >= 8) begin
        cb.byte_val = 8'(acc >> (nbits - 8));
        cb.last = 1'b0;
        expected_bytes.push_back(cb);
        produced++;
        nbits -= 8;
        acc = acc & ((32'd1 << nbits) - 1);
      end
    end
    if (produced > 0) begin
      cb = expected_bytes.pop_back();
      cb.last = 1'b1;
      expected_bytes.push_back(cb);
    end
    held_bits = acc[6:0];
    held_count = nbits[2:0];
  endtask

  // Sender: keeps valid and payload steady until the item is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_items.size() > 0 && !sender_hold &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        in_valid <= 1'b1;
        in_data_byte <= next_item.data_byte;
        in_first_byte <= next_item.first_byte;
      end else begin
        in_valid <= 1'b0;
        in_data_byte <= 8'($urandom);
        in_first_byte <= 1'($urandom);
      end
    end
  end

  // Receiver: a requested hold-off takes priority over random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      out_ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Prediction runs before the check so a same-edge result would still find its entry.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        encode_item(in_data_byte, in_first_byte);
        items_taken++;
      end
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte %02h arrived with no expected byte pending", out_out_byte);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_out_byte !== want.byte_val) begin
            $error("out_byte mismatch: expected %02h, got %02h", want.byte_val, out_out_byte);
            errors++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, out_last);
            errors++;
          end
        end
      end
    end
  end

  task automatic write_reg(ccbp_reg_t idx, logic [8:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GEN_BITS: gen_bits_sh = value;
      REG_GEN_LEN:  gen_len_sh = value[3:0];
      REG_WORD_SEL: wide_sh = value[0];
      REG_LEAD_PAD: lead_pad_sh = value[2:0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry random noise; the block must ignore them.
  task automatic set_config(logic [8:0] gen, logic [3:0] len, logic wide, logic [2:0] pad);
    logic [8:0] noise;
    noise = 9'($urandom);
    write_reg(REG_GEN_BITS, gen);
    write_reg(REG_GEN_LEN, {noise[8:4], len});
    write_reg(REG_WORD_SEL, {noise[8:1], wide});
    write_reg(REG_LEAD_PAD, {noise[8:3], pad});
  endtask

  task automatic random_config();
    logic [3:0] len;
    int         pick;
    pick = $urandom_range(0, 5);
    if (pick == 0) len = 4'($urandom_range(10, 15));
    else if (pick == 1) len = 4'd0;
    else len = 4'($urandom_range(1, 9));
    set_config(9'($urandom), len, 1'($urandom), 3'($urandom));
  endtask

  task automatic add_item(logic [7:0] data, logic first);
    raw_item_t it;
    it.data_byte = data;
    it.first_byte = first;
    pending_items.push_back(it);
  endtask

  // Mostly streams that open with a first byte; a stray first byte shows up now and then.
  task automatic queue_streams(int n_items);
    int run_left;
    run_left = 0;
    for (int k = 0; k < n_items; k++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 12);
        add_item(8'($urandom), 1'b1);
      end else begin
        case ($urandom_range(0, 7))
          0: add_item(8'h00, $urandom_range(0, 19) == 0);
          1: add_item(8'hFF, $urandom_range(0, 19) == 0);
          default: add_item(8'($urandom), $urandom_range(0, 19) == 0);
        endcase
      end
      run_left--;
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_bytes.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic random_phase(int n_items, int send_pct, int recv_pct, int hold, bit pause_mid);
    int goal;
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    rx_hold_left = hold;
    goal = items_taken + n_items / 2;
    queue_streams(n_items);
    if (pause_mid) begin
      while (items_taken < goal) @(negedge clk);
      sender_hold = 1'b1;
      while (in_valid || expected_bytes.size() > 0) @(negedge clk);
      sender_hold = 1'b0;
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration; the first item continues from the cleared held bits.
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'h5A, 1'b1);
    drain();

    // Longest codewords with full padding: two bytes per item.
    set_config(9'h107, 4'd9, 1'b1, 3'd7);
    add_item(8'hFF, 1'b1);
    add_item(8'h00, 1'b0);
    add_item(8'h80, 1'b0);
    add_item(8'h01, 1'b0);
    drain();

    // A zero generator length behaves as length one.
    set_config(9'h1FF, 4'd0, 1'b0, 3'd3);
    add_item(8'hA5, 1'b1);
    add_item(8'h3C, 1'b0);
    drain();

    // An overlong generator length is clamped to the maximum.
    set_config(9'h1FF, 4'd15, 1'b0, 3'd5);
    add_item(8'hFF, 1'b1);
    add_item(8'h96, 1'b0);
    add_item(8'h01, 1'b0);
    drain();

    // Generator whose leading bit is zero.
    set_config(9'h00B, 4'd5, 1'b1, 3'd0);
    add_item(8'hC3, 1'b1);
    add_item(8'h7E, 1'b0);
    add_item(8'h10, 1'b0);
    drain();

    set_config(9'h003, 4'd2, 1'b0, 3'd1);
    add_item(8'h69, 1'b1);
    add_item(8'hF0, 1'b0);
    drain();

    set_config(9'($urandom) | 9'h100, 4'd9, 1'b1, 3'd7);
    random_phase(50, 0, 0, 0, 1'b0);
    set_config(9'($urandom), 4'd1, 1'b0, 3'd0);
    random_phase(40, 86, 0, 0, 1'b0);
    random_config();
    random_phase(50, 0, 86, 0, 1'b0);
    random_config();
    random_phase(50, 22, 22, 0, 1'b0);
    // Long receiver hold-off while the sender keeps offering items.
    random_config();
    random_phase(50, 0, 0, 300, 1'b0);
    random_config();
    random_phase(50, 22, 22, 0, 1'b1);
    random_config();
    random_phase(60, 0, 0, 0, 1'b0);

    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
